FILE: rtl/core/rwcs_pkg.sv
// shared types, field widths, register codes and constants for the wall column setup
package rwcs_pkg;

    localparam int ANGLE_BITS_DEF    = 12;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam int ANGLE_W   = 12;
    localparam int DIST_W    = 16;
    localparam int IMPACT_W  = 16;
    localparam int WSIDE_W   = 3;
    localparam int H_W       = 12;
    localparam int TILT_W    = 12;
    localparam int TEX_W     = 11;
    localparam int SEL_W     = 2;
    localparam int ROW_W     = 12;
    localparam int HW_W      = 16;
    localparam int COL_W     = 10;
    localparam int TR_W      = 15;
    localparam int STEP_W    = 27;
    localparam int FOG_W     = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_OFFSET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NIGHT_MODE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_HEIGHT = 3'd4;

    localparam logic [WSIDE_W-1:0] SIDE_EAST = 3'd1;
    localparam logic [WSIDE_W-1:0] SIDE_WEST = 3'd4;

    // cosine polynomial coefficients, Q16
    localparam logic [16:0] COS_C2  = 17'd80852;
    localparam logic [14:0] COS_C4  = 15'd16625;
    localparam logic [10:0] COS_C6  = 11'd1367;
    localparam logic [6:0]  COS_C8  = 7'd60;
    localparam logic [16:0] COS_ONE = 17'd65536;

    localparam logic [HW_W-1:0]   HW_MAX   = 16'hFFFF;
    localparam logic [TR_W-1:0]   TR_MAX   = 15'h7FFF;
    localparam logic [STEP_W-1:0] STEP_MAX = 27'd67108864;
    localparam logic [FOG_W-1:0]  FOG_MAX  = 9'd256;
    localparam logic [COL_W-1:0]  COL_MAX  = 10'd1023;
    localparam int FOG_K_H  = 3328;
    localparam int FOG_K_HW = 89600;

    typedef struct packed {
        logic             draw;
        logic [SEL_W-1:0] tsel;
        logic [COL_W-1:0] col;
    } t_tag;

    typedef struct packed {
        logic [H_W-1:0]           screen_height;
        logic signed [TILT_W-1:0] tilt;
        logic                     night;
        logic [TEX_W-1:0]         tex_w;
        logic [TEX_W-1:0]         tex_h;
    } t_cfg;

endpackage

FILE: rtl/core/rwcs_div.sv
// pipelined restoring divider, one quotient bit per stage, with sideband
module rwcs_div
    import rwcs_pkg::*;
#(
    parameter int NUM_W  = 27,
    parameter int DEN_W  = 16,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [NUM_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_vld  [NUM_W];
    logic [NUM_W-1:0]  r_num  [NUM_W];
    logic [NUM_W-1:0]  r_quo  [NUM_W];
    logic [DEN_W-1:0]  r_rem  [NUM_W];
    logic [DEN_W-1:0]  r_den  [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic              vld_in;
        logic [NUM_W-1:0]  num_in;
        logic [NUM_W-1:0]  quo_in;
        logic [DEN_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              qbit;

        if (k == 0) begin : g_first
            assign vld_in  = i_vld;
            assign num_in  = i_num;
            assign quo_in  = '0;
            assign rem_in  = '0;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign num_in  = r_num[k-1];
            assign quo_in  = r_quo[k-1];
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
        end

        assign trial = {rem_in, num_in[NUM_W-1]};
        assign qbit  = (trial >= {1'b0, den_in});
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        // a zero divisor yields an all-ones quotient
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_num[k]  <= num_in << 1;
                r_quo[k]  <= {quo_in[NUM_W-2:0], qbit};
                r_den[k]  <= den_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[NUM_W-1];
    assign o_quo  = r_quo[NUM_W-1];
    assign o_side = r_side[NUM_W-1];

endmodule

FILE: rtl/core/rwcs_queue.sv
// small register queue between the front classifier and the back pipeline
module rwcs_queue
    import rwcs_pkg::*;
#(
    parameter int DEPTH  = QUEUE_DEPTH_DEF,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [AW:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

FILE: rtl/core/rwcs_front.sv
// front: classifies a ray, folds the angle and works out the texture column
module rwcs_front
    import rwcs_pkg::*;
#(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic [ANGLE_W-1:0]    i_angle_diff,
    input  logic [IMPACT_W-1:0]   i_impact_x,
    input  logic [IMPACT_W-1:0]   i_impact_y,
    input  logic [WSIDE_W-1:0]    i_wall_side,
    input  logic [TEX_W-1:0]      i_tex_w,
    output t_tag                  o_tag,
    output logic [ANGLE_BITS-3:0] o_mag
);

    localparam int FB = FRACTION_BITS;
    localparam int PW = FB + 12;

    logic [15:0]            a16;
    logic [ANGLE_BITS-1:0]  a;
    logic [ANGLE_BITS-1:0]  mag;
    logic                   side_ok;
    logic                   in_front;
    logic [FB:0]            fsum;
    logic [PW-1:0]          prod;
    logic [11:0]            col_raw;
    logic [11:0]            col_lim;
    logic [11:0]            col_sat;

    always_comb begin
        a16      = {{(16-ANGLE_W){1'b0}}, i_angle_diff};
        a        = a16[ANGLE_BITS-1:0];
        mag      = a[ANGLE_BITS-1] ? (~a + 1'b1) : a;
        side_ok  = (i_wall_side >= SIDE_EAST) && (i_wall_side <= SIDE_WEST);
        // a quarter turn or more is behind the view plane
        in_front = (mag[ANGLE_BITS-1:ANGLE_BITS-2] == 2'b00);

        fsum    = {1'b0, i_impact_x[FB-1:0]} + {1'b0, i_impact_y[FB-1:0]};
        prod    = PW'(fsum) * PW'(i_tex_w);
        col_raw = prod[PW-1:FB];
        col_lim = {1'b0, i_tex_w} - 12'd1;
        if (i_tex_w == '0) begin
            col_sat = '0;
        end else if (col_raw > col_lim) begin
            col_sat = col_lim;
        end else begin
            col_sat = col_raw;
        end

        o_tag.draw = side_ok && in_front;
        o_tag.tsel = SEL_W'(i_wall_side - SIDE_EAST);
        o_tag.col  = (col_sat > 12'(COL_MAX)) ? COL_MAX : col_sat[COL_W-1:0];
        o_mag      = mag[ANGLE_BITS-3:0];
    end

endmodule

FILE: rtl/core/rwcs_back.sv
// back: cosine, fisheye correction, projection divide, rows, step and fog
module rwcs_back
    import rwcs_pkg::*;
#(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  t_tag                  i_tag,
    input  logic [ANGLE_BITS-3:0] i_mag,
    input  logic [DIST_W-1:0]     i_dist,
    input  t_cfg                  i_cfg,
    output logic                  o_vld,
    output logic                  o_draw_valid,
    output logic [SEL_W-1:0]      o_texture_select,
    output logic [ROW_W-1:0]      o_row_start,
    output logic [ROW_W-1:0]      o_row_end,
    output logic [HW_W-1:0]       o_wall_height,
    output logic [COL_W-1:0]      o_texture_column,
    output logic [TR_W-1:0]       o_texture_row_start,
    output logic [STEP_W-1:0]     o_texture_row_step,
    output logic [FOG_W-1:0]      o_fog_level
);

    localparam int USH  = 18 - ANGLE_BITS;
    localparam int D1_W = H_W + FRACTION_BITS;
    localparam int TG_W = $bits(t_tag);

    typedef struct packed {
        t_tag             tag;
        logic [HW_W-1:0]  hw;
        logic [ROW_W-1:0] y0;
        logic [ROW_W-1:0] y1;
        logic [TR_W-1:0]  tr;
    } t_geo;

    // cosine and distance stages
    logic        r_vld [6];
    t_tag        r_tag [6];
    logic [15:0] r_dist [5];
    logic [15:0] r_w [4];
    logic [10:0] r_t2;
    logic [14:0] r_t3;
    logic [16:0] r_t4;
    logic [16:0] r_c;
    logic [15:0] r_g;

    logic [15:0] u;
    logic [31:0] uu;
    logic [6:0]  t1;
    logic [22:0] p1;
    logic [26:0] p2;
    logic [30:0] p3;
    logic [32:0] p4;
    logic [16:0] s4;
    logic [32:0] p5;

    always_comb begin
        u  = 16'(i_mag) << USH;
        uu = 32'(u) * 32'(u);
        t1 = COS_C8 - {6'd0, r_w[0][15]};
        p1 = 23'(r_w[0]) * 23'(t1);
        p2 = 27'(r_w[1]) * 27'(r_t2);
        p3 = 31'(r_w[2]) * 31'(r_t3);
        p4 = 33'(r_w[3]) * 33'(r_t4);
        s4 = p4[32:16];
        p5 = 33'(r_dist[4]) * 33'(r_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < 6; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0]  <= i_tag;
            r_dist[0] <= i_dist;
            r_w[0]    <= uu[31:16];
            for (int k = 1; k < 6; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
            for (int k = 1; k < 5; k++) begin
                r_dist[k] <= r_dist[k-1];
            end
            for (int k = 1; k < 4; k++) begin
                r_w[k] <= r_w[k-1];
            end
            r_t2 <= COS_C6 - {4'd0, p1[22:16]};
            r_t3 <= COS_C4 - {4'd0, p2[26:16]};
            r_t4 <= COS_C2 - {2'd0, p3[30:16]};
            r_c  <= (s4 > COS_ONE) ? 17'd0 : (COS_ONE - s4);
            r_g  <= p5[31:16];
        end
    end

    // projection divide: screen height over corrected distance
    logic            d1_vld;
    logic [D1_W-1:0] d1_quo;
    logic [TG_W-1:0] d1_side;

    rwcs_div #(
        .NUM_W  (D1_W),
        .DEN_W  (16),
        .SIDE_W (TG_W)
    ) u_div_height (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (i_en),
        .i_vld  (r_vld[5]),
        .i_num  ({i_cfg.screen_height, {FRACTION_BITS{1'b0}}}),
        .i_den  (r_g),
        .i_side (r_tag[5]),
        .o_vld  (d1_vld),
        .o_quo  (d1_quo),
        .o_side (d1_side)
    );

    // rows, texture start and fog numerator
    logic [HW_W-1:0]  hw;
    logic [14:0]      ht;
    logic [17:0]      ht18;
    logic [17:0]      v0;
    logic [17:0]      v1;
    logic [17:0]      nv0;
    logic [16:0]      y0_raw;
    logic [16:0]      y1_raw;
    logic [ROW_W-1:0] y1;
    logic [ROW_W-1:0] y0;
    logic [TR_W-1:0]  tr;
    logic [23:0]      fk;
    logic [32:0]      fh;
    logic             fpos;
    t_geo             geo;

    always_comb begin
        hw     = ((d1_quo >> 16) != '0) ? HW_MAX : d1_quo[HW_W-1:0];
        ht     = {3'd0, i_cfg.screen_height}
               + {{2{i_cfg.tilt[TILT_W-1]}}, i_cfg.tilt, 1'b0};
        ht18   = {{3{ht[14]}}, ht};
        v0     = ht18 - {2'd0, hw};
        v1     = ht18 + {2'd0, hw};
        nv0    = ~v0 + 1'b1;
        y0_raw = v0[17] ? 17'd0 : v0[17:1];
        y1_raw = v1[17] ? 17'd0 : v1[17:1];
        y1     = (y1_raw > 17'(i_cfg.screen_height)) ? i_cfg.screen_height
                                                      : y1_raw[ROW_W-1:0];
        y0     = (y0_raw > 17'(y1)) ? y1 : y0_raw[ROW_W-1:0];
        // wall taller than the screen: skip the rows above the top edge
        if (!v0[17]) begin
            tr = '0;
        end else if (nv0[17:1] > 17'(TR_MAX)) begin
            tr = TR_MAX;
        end else begin
            tr = nv0[TR_W:1];
        end
        fk   = 24'(i_cfg.screen_height) * 24'(FOG_K_H);
        fh   = 33'(hw) * 33'(FOG_K_HW);
        fpos = ({9'd0, fk} > fh);

        geo.tag = t_tag'(d1_side);
        geo.hw  = hw;
        geo.y0  = y0;
        geo.y1  = y1;
        geo.tr  = tr;
    end

    logic        r_vld6;
    t_geo        r_geo;
    logic [23:0] r_fnum;
    logic        r_fen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld6 <= 1'b0;
        end else if (i_en) begin
            r_vld6 <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_geo  <= geo;
            r_fnum <= fpos ? (fk - fh[23:0]) : 24'd0;
            r_fen  <= i_cfg.night && fpos;
        end
    end

    // texture step and fog divides run side by side
    logic              d2_vld;
    logic [STEP_W-1:0] d2_quo;
    t_geo              d2_geo;
    logic              d3_vld;
    logic [STEP_W-1:0] d3_quo;
    logic              d3_fen;

    rwcs_div #(
        .NUM_W  (STEP_W),
        .DEN_W  (16),
        .SIDE_W ($bits(t_geo))
    ) u_div_step (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (i_en),
        .i_vld  (r_vld6),
        .i_num  ({i_cfg.tex_h, 16'd0}),
        .i_den  (r_geo.hw),
        .i_side (r_geo),
        .o_vld  (d2_vld),
        .o_quo  (d2_quo),
        .o_side (d2_geo)
    );

    rwcs_div #(
        .NUM_W  (STEP_W),
        .DEN_W  (16),
        .SIDE_W (1)
    ) u_div_fog (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (i_en),
        .i_vld  (r_vld6),
        .i_num  (STEP_W'(r_fnum)),
        .i_den  (16'(i_cfg.screen_height) * 16'd5),
        .i_side (r_fen),
        .o_vld  (d3_vld),
        .o_quo  (d3_quo),
        .o_side (d3_fen)
    );

    // output register
    logic r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= d2_vld && d3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!d2_geo.tag.draw) begin
                o_draw_valid        <= 1'b0;
                o_texture_select    <= '0;
                o_row_start         <= '0;
                o_row_end           <= '0;
                o_wall_height       <= '0;
                o_texture_column    <= '0;
                o_texture_row_start <= '0;
                o_texture_row_step  <= '0;
                o_fog_level         <= '0;
            end else begin
                o_draw_valid        <= 1'b1;
                o_texture_select    <= d2_geo.tag.tsel;
                o_row_start         <= d2_geo.y0;
                o_row_end           <= d2_geo.y1;
                o_wall_height       <= d2_geo.hw;
                o_texture_column    <= d2_geo.tag.col;
                o_texture_row_start <= d2_geo.tr;
                o_texture_row_step  <= (d2_quo > STEP_MAX) ? STEP_MAX : d2_quo;
                if (!d3_fen) begin
                    o_fog_level <= '0;
                end else if (d3_quo > STEP_W'(FOG_MAX)) begin
                    o_fog_level <= FOG_MAX;
                end else begin
                    o_fog_level <= d3_quo[FOG_W-1:0];
                end
            end
        end
    end

    assign o_vld = r_out_vld;

endmodule

FILE: rtl/core/raycast_wall_column_setup_top.sv
// Wall column setup: one ray per cycle in, one column descriptor per cycle out.
// From accepted beat to result shown, a beat passes the six cosine and distance multiply
// stages, the 12 + FRACTION_BITS stage height divider and the 27 stage step and fog
// dividers; throughput is one beat per cycle while pop keeps up.
// Reset (synchronous, active low) empties the queue and pipeline and restores the
// register defaults: height 720, tilt 0, night off, texture 64 by 64.
module raycast_wall_column_setup_top
    import rwcs_pkg::*;
#(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [ANGLE_W-1:0]   i_angle_diff,
    input  logic [DIST_W-1:0]    i_ray_distance,
    input  logic [IMPACT_W-1:0]  i_impact_x,
    input  logic [IMPACT_W-1:0]  i_impact_y,
    input  logic [WSIDE_W-1:0]   i_wall_side,
    output logic                 empty,
    input  logic                 pop,
    output logic                 o_draw_valid,
    output logic [SEL_W-1:0]     o_texture_select,
    output logic [ROW_W-1:0]     o_row_start,
    output logic [ROW_W-1:0]     o_row_end,
    output logic [HW_W-1:0]      o_wall_height,
    output logic [COL_W-1:0]     o_texture_column,
    output logic [TR_W-1:0]      o_texture_row_start,
    output logic [STEP_W-1:0]    o_texture_row_step,
    output logic [FOG_W-1:0]     o_fog_level,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int MAG_W = ANGLE_BITS - 2;
    localparam int Q_W   = $bits(t_tag) + DIST_W + MAG_W;

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_height <= 12'd720;
            r_cfg.tilt          <= '0;
            r_cfg.night         <= 1'b0;
            r_cfg.tex_w         <= 11'd64;
            r_cfg.tex_h         <= 11'd64;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SCREEN_HEIGHT:  r_cfg.screen_height <= i_cfg_data;
                REG_TILT_OFFSET:    r_cfg.tilt          <= i_cfg_data;
                REG_NIGHT_MODE:     r_cfg.night         <= i_cfg_data[0];
                REG_TEXTURE_WIDTH:  r_cfg.tex_w         <= i_cfg_data[TEX_W-1:0];
                REG_TEXTURE_HEIGHT: r_cfg.tex_h         <= i_cfg_data[TEX_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // front
    t_tag             f_tag;
    logic [MAG_W-1:0] f_mag;

    rwcs_front #(
        .ANGLE_BITS   (ANGLE_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .i_angle_diff(i_angle_diff),
        .i_impact_x  (i_impact_x),
        .i_impact_y  (i_impact_y),
        .i_wall_side (i_wall_side),
        .i_tex_w     (r_cfg.tex_w),
        .o_tag       (f_tag),
        .o_mag       (f_mag)
    );

    // queue between front and back
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    logic [Q_W-1:0] q_data;
    logic           en;
    logic           b_vld;

    assign en    = !b_vld || pop;
    assign q_pop = en && !q_empty;

    rwcs_queue #(
        .DEPTH (QUEUE_DEPTH),
        .DATA_W(Q_W)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push && !q_full),
        .i_data ({f_tag, i_ray_distance, f_mag}),
        .i_pop  (q_pop),
        .o_data (q_data),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    assign full = q_full;

    // back
    rwcs_back #(
        .ANGLE_BITS   (ANGLE_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_en               (en),
        .i_vld              (!q_empty),
        .i_tag              (t_tag'(q_data[Q_W-1:DIST_W+MAG_W])),
        .i_mag              (q_data[MAG_W-1:0]),
        .i_dist             (q_data[DIST_W+MAG_W-1:MAG_W]),
        .i_cfg              (r_cfg),
        .o_vld              (b_vld),
        .o_draw_valid       (o_draw_valid),
        .o_texture_select   (o_texture_select),
        .o_row_start        (o_row_start),
        .o_row_end          (o_row_end),
        .o_wall_height      (o_wall_height),
        .o_texture_column   (o_texture_column),
        .o_texture_row_start(o_texture_row_start),
        .o_texture_row_step (o_texture_row_step),
        .o_fog_level        (o_fog_level)
    );

    assign empty = !b_vld;

    // a dropped column carries no geometry
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_draw_valid) |->
            (o_wall_height == '0) && (o_texture_row_step == '0) && (o_fog_level == '0))
        else $error("dropped column carries nonzero fields");

    a_rows_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_draw_valid) |-> (o_row_start <= o_row_end))
        else $error("row span inverted");

    a_rows_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_draw_valid) |-> (o_row_end <= r_cfg.screen_height))
        else $error("row end beyond screen");

    a_fog_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_fog_level <= FOG_MAX) && (o_texture_row_step <= STEP_MAX))
        else $error("fog or step out of range");

endmodule

FILE: dv/tb_raycast_wall_column_setup_top.sv
// testbench for the wall column setup: random rays and stalls checked against a behavioral predictor
`timescale 1ns / 100ps

module tb_raycast_wall_column_setup_top;
    import rwcs_pkg::*;

    localparam int LATENCY   = 60;
    localparam int WDOG_MAX  = 4000;
    localparam int PHASE_RAYS = 120;

    typedef struct {
        logic [ANGLE_W-1:0]  angle;
        logic [DIST_W-1:0]   distance;
        logic [IMPACT_W-1:0] ix;
        logic [IMPACT_W-1:0] iy;
        logic [WSIDE_W-1:0]  side;
    } t_ray;

    typedef struct {
        logic              draw;
        logic [SEL_W-1:0]  tsel;
        logic [ROW_W-1:0]  row0;
        logic [ROW_W-1:0]  row1;
        logic [HW_W-1:0]   hw;
        logic [COL_W-1:0]  col;
        logic [TR_W-1:0]   tr;
        logic [STEP_W-1:0] step;
        logic [FOG_W-1:0]  fog;
    } t_column;

    class column_scoreboard;
        t_column     pending_cols[$];
        int          errors;
        longint unsigned scr_h, night, tex_w, tex_h;
        longint      tilt;

        function new();
            errors = 0;
            scr_h = 720; tilt = 0; night = 0; tex_w = 64; tex_h = 64;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                REG_SCREEN_HEIGHT:  scr_h = 64'(val);
                REG_TILT_OFFSET:    tilt = longint'($signed(val));
                REG_NIGHT_MODE:     night = 64'(val[0]);
                REG_TEXTURE_WIDTH:  tex_w = 64'(val[TEX_W-1:0]);
                REG_TEXTURE_HEIGHT: tex_h = 64'(val[TEX_W-1:0]);
                default: ;
            endcase
        endfunction

        function t_column project(t_ray r);
            t_column c;
            longint unsigned m, u, w, t, s, cs, g, hw, step, col, fog;
            longint y0, y1, hh, h2t, v, num;
            c = '{default: '0};
            m = r.angle[ANGLE_W-1] ? 64'(4096 - r.angle) : 64'(r.angle);
            if (r.side < 1 || r.side > 4 || m >= 1024) return c;
            u = (m << 16) >> 10;
            w = (u * u) >> 16;
            t = 60 - ((w * 2) >> 16);
            t = 1367 - ((w * t) >> 16);
            t = 16625 - ((w * t) >> 16);
            t = 80852 - ((w * t) >> 16);
            s = (w * t) >> 16;
            cs = (s > 65536) ? 0 : 65536 - s;
            g = (64'(r.distance) * cs) >> 16;
            if (g == 0) hw = 65535;
            else begin
                hw = (scr_h << 8) / g;
                if (hw > 65535) hw = 65535;
            end
            hh = longint'(scr_h);
            h2t = 2 * tilt;
            v = hh - longint'(hw) + h2t;
            y0 = v < 0 ? 0 : v / 2;
            v = hh + longint'(hw) + h2t;
            y1 = v < 0 ? 0 : v / 2;
            if (y1 > hh) y1 = hh;
            if (y0 > y1) y0 = y1;
            if (longint'(hw) > hh + h2t) begin
                v = (longint'(hw) - hh - h2t) / 2;
                c.tr = TR_W'(v > 32767 ? 32767 : v);
            end
            if (hw == 0) step = 67108864;
            else begin
                step = (tex_h << 16) / hw;
                if (step > 67108864) step = 67108864;
            end
            col = (64'(r.ix[7:0]) + 64'(r.iy[7:0])) * tex_w >> 8;
            if (tex_w == 0) col = 0;
            else if (col > tex_w - 1) col = tex_w - 1;
            if (col > 1023) col = 1023;
            fog = 0;
            if (night == 1 && scr_h != 0) begin
                num = 3328 * hh - 89600 * longint'(hw);
                if (num > 0) begin
                    fog = 64'(num) / (5 * scr_h);
                    if (fog > 256) fog = 256;
                end
            end
            c.draw = 1'b1;
            c.tsel = SEL_W'(r.side - 1);
            c.row0 = ROW_W'(y0);
            c.row1 = ROW_W'(y1);
            c.hw   = HW_W'(hw);
            c.col  = COL_W'(col);
            c.step = STEP_W'(step);
            c.fog  = FOG_W'(fog);
            return c;
        endfunction

        function void note_ray(t_ray r);
            pending_cols.push_back(project(r));
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task check_column(t_column got);
            t_column e;
            if (pending_cols.size() == 0) begin
                report("unexpected column beat", 1, 0);
                return;
            end
            e = pending_cols.pop_front();
            if (got.draw !== e.draw) report("draw_valid", got.draw, e.draw);
            if (got.tsel !== e.tsel) report("texture_select", got.tsel, e.tsel);
            if (got.row0 !== e.row0) report("row_start", got.row0, e.row0);
            if (got.row1 !== e.row1) report("row_end", got.row1, e.row1);
            if (got.hw !== e.hw) report("wall_height", got.hw, e.hw);
            if (got.col !== e.col) report("texture_column", got.col, e.col);
            if (got.tr !== e.tr) report("texture_row_start", got.tr, e.tr);
            if (got.step !== e.step) report("texture_row_step", got.step, e.step);
            if (got.fog !== e.fog) report("fog_level", got.fog, e.fog);
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    logic [ANGLE_W-1:0]   i_angle_diff;
    logic [DIST_W-1:0]    i_ray_distance;
    logic [IMPACT_W-1:0]  i_impact_x;
    logic [IMPACT_W-1:0]  i_impact_y;
    logic [WSIDE_W-1:0]   i_wall_side;
    logic                 empty;
    logic                 pop;
    logic                 o_draw_valid;
    logic [SEL_W-1:0]     o_texture_select;
    logic [ROW_W-1:0]     o_row_start;
    logic [ROW_W-1:0]     o_row_end;
    logic [HW_W-1:0]      o_wall_height;
    logic [COL_W-1:0]     o_texture_column;
    logic [TR_W-1:0]      o_texture_row_start;
    logic [STEP_W-1:0]    o_texture_row_step;
    logic [FOG_W-1:0]     o_fog_level;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    column_scoreboard sb;
    t_ray cur_ray;
    bit   no_idle;
    int   idle_cycles;

    raycast_wall_column_setup_top u_top (.*);

    always #2 i_clk = ~i_clk;

    initial begin
        sb = new();
        i_rst_n = 1'b0; push = 1'b0; pop = 1'b0; i_cfg_valid = 1'b0;
        i_cfg_index = '0; i_cfg_data = '0;
        i_angle_diff = '0; i_ray_distance = '0; i_impact_x = '0; i_impact_y = '0;
        i_wall_side = '0;
        no_idle = 1'b0;
    end

    // accepted rays go to the scoreboard
    always @(posedge i_clk)
        if (i_rst_n && push && !full) sb.note_ray(cur_ray);

    // watchdog on lack of progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WDOG_MAX) begin
            $display("** raycast_wall_column_setup_top: FAILED **");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 6);
    endfunction

    task automatic send_ray(t_ray r);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cur_ray        <= r;
        push           <= 1'b1;
        i_angle_diff   <= r.angle;
        i_ray_distance <= r.distance;
        i_impact_x     <= r.ix;
        i_impact_y     <= r.iy;
        i_wall_side    <= r.side;
        do @(posedge i_clk); while (full);
    endtask

    // valid stays high across back to back writes, the caller drops it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.pending_cols.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic set_all(int h, int tilt, int night, int tw, int th);
        drain();
        write_reg(REG_SCREEN_HEIGHT, CFG_DAT_W'(h));
        write_reg(REG_TILT_OFFSET, CFG_DAT_W'(tilt));
        write_reg(REG_NIGHT_MODE, CFG_DAT_W'(night));
        write_reg(REG_TEXTURE_WIDTH, CFG_DAT_W'(tw));
        write_reg(REG_TEXTURE_HEIGHT, CFG_DAT_W'(th));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_ray rand_ray();
        t_ray r;
        int sel;
        sel = $urandom_range(0, 9);
        r.angle = (sel < 8) ? ANGLE_W'($urandom_range(0, 1023)) : ANGLE_W'($urandom);
        if ($urandom_range(0, 1)) r.angle = -r.angle;
        case ($urandom_range(0, 3))
            0: r.distance = DIST_W'($urandom_range(0, 64));
            1: r.distance = DIST_W'($urandom_range(0, 2048));
            default: r.distance = DIST_W'($urandom);
        endcase
        r.ix = IMPACT_W'($urandom);
        r.iy = IMPACT_W'($urandom);
        r.side = (sel == 9) ? WSIDE_W'($urandom_range(0, 7)) : WSIDE_W'($urandom_range(1, 4));
        return r;
    endfunction

    task automatic random_rays(int n);
        repeat (n) begin
            if ($urandom_range(0, 39) == 0) no_idle = ~no_idle;
            send_ray(rand_ray());
        end
    endtask

    // result side with random stalls
    initial begin
        t_column got;
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            got.draw = o_draw_valid;
            got.tsel = o_texture_select;
            got.row0 = o_row_start;
            got.row1 = o_row_end;
            got.hw   = o_wall_height;
            got.col  = o_texture_column;
            got.tr   = o_texture_row_start;
            got.step = o_texture_row_step;
            got.fog  = o_fog_level;
            sb.check_column(got);
        end
    end

    initial begin
        t_ray r;
        int angles[7];
        int dists[5];
        angles = '{0, 1023, -1023, 1024, -1024, 2047, -2048};
        dists  = '{0, 1, 256, 65535, 40};
        #0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults first: angle and distance extremes, every side
        foreach (angles[k]) begin
            r = '{angle: ANGLE_W'(angles[k]), distance: DIST_W'(dists[k % 5]),
                  ix: 16'hFFFF, iy: 16'hFFFF, side: WSIDE_W'(1 + k % 4)};
            send_ray(r);
        end
        foreach (dists[k]) begin
            r = '{angle: '0, distance: DIST_W'(dists[k]), ix: '0, iy: '0, side: 3'd2};
            send_ray(r);
        end
        for (int s = 0; s < 8; s++) begin
            r = '{angle: 12'd100, distance: 16'd300, ix: 16'h00FF, iy: 16'h0080,
                  side: WSIDE_W'(s)};
            send_ray(r);
        end
        random_rays(PHASE_RAYS);

        set_all(2048, 1024, 1, 1024, 1024);
        random_rays(PHASE_RAYS);
        set_all(1, -1024, 1, 1, 1);
        random_rays(PHASE_RAYS);
        // zero height and zero texture sizes
        set_all(0, 0, 1, 0, 0);
        random_rays(PHASE_RAYS / 2);
        for (int p = 0; p < 2; p++) begin
            set_all($urandom_range(1, 2048), $urandom_range(0, 2048) - 1024,
                    $urandom_range(0, 1), $urandom_range(1, 1024), $urandom_range(1, 1024));
            random_rays(PHASE_RAYS);
        end

        drain();
        if (sb.errors == 0)
            $display("** raycast_wall_column_setup_top: PASSED **");
        else
            $display("** raycast_wall_column_setup_top: FAILED **");
        $finish;
    end

endmodule
